FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the checker RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define ACKFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define ACKFC_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

FILE: rtl/core/ackfc_pkg.sv
// Shared types, constants and the CRC-16 byte step for the ack frame checker
package ackfc_pkg;

    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_TOP       = 16'h8000;
    localparam logic [7:0]  ACK_KIND      = 8'd7;
    localparam logic [15:0] MIN_FRAME_LEN = 16'd9;
    localparam logic [15:0] POS_MAX       = 16'hFFFF;
    localparam logic [15:0] SEG_MAX       = 16'hFFFF;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HEADER_CODE   = 3'd0,
        REG_RESP_TYPE     = 3'd1,
        REG_RECEIVED_CODE = 3'd2,
        REG_NO_ERROR_CODE = 3'd3,
        REG_SEGMENT_COUNT = 3'd4
    } cfg_reg_t;

    // Frame outcome codes
    typedef enum logic [2:0] {
        OUT_IGNORED   = 3'd0,
        OUT_CRC_ERROR = 3'd1,
        OUT_BAD_LEN   = 3'd2,
        OUT_SEND_NEXT = 3'd3,
        OUT_RESEND    = 3'd4,
        OUT_COMPLETE  = 3'd5
    } outcome_t;

    typedef struct packed {
        logic [7:0]  header_code;
        logic [7:0]  response_type_code;
        logic [7:0]  received_code;
        logic [7:0]  no_error_code;
        logic [15:0] segment_count;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        outcome_t    outcome;
        logic [15:0] segment_index;
        logic [15:0] computed_crc;
    } res_t;

    // One byte through CRC-16 (poly 0x1021, MSB first), unrolled over 8 bits
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/ack_frame_checker_segment_sequencer.sv
// Top level of the acknowledgement frame checker and segment sequencer
//
// Usage:
//   Item channel (item_valid / item_stall) carries one received byte per
//   transaction with frame_start marking byte 0 and rewind zeroing the
//   segment index. Result channel (result_valid / result_stall) carries one
//   transaction per finished frame: outcome, segment_index, computed_crc.
//   Bytes that end no frame produce no result transaction.
//   Throughput is one byte per cycle while result_stall is low: the CRC
//   byte step is unrolled and the whole parse/judge path sits between the
//   input register and the result register. An accepted byte waits in the
//   input register, and its result then goes into the result register.
//   When result_stall holds a waiting result, one more byte is taken into the
//   input register; item_stall then rises until the result is taken.
//   Configuration (cfg_we / cfg_index / cfg_data) writes one register per
//   cycle; the user must write it only while the block is idle, which the block does not enforce.
//   Reset clears all configuration, the frame state and the segment index;
//   both channel registers come up empty.
`include "assert_macros.svh"

module ack_frame_checker_segment_sequencer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ackfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ackfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [7:0]                        rx_byte,
    input  logic                              frame_start,
    input  logic                              rewind,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [2:0]                        outcome,
    output logic [15:0]                       segment_index,
    output logic [15:0]                       computed_crc
);

    ackfc_pkg::cfg_t cfg;
    ackfc_pkg::res_t res;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        in_rewind_reg;
    logic        out_valid_reg, out_valid_next;
    ackfc_pkg::outcome_t out_outcome_reg;
    logic [15:0] out_seg_reg;
    logic [15:0] out_crc_reg;
    logic        advance;
    logic        accept;
    logic        step;

    ackfc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ackfc_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (in_byte_reg),
        .frame_start (in_start_reg),
        .rewind      (in_rewind_reg),
        .cfg         (cfg),
        .res         (res)
    );

    // Handshake: the result register frees the stage, the stage frees the input
    always_comb
    begin
        advance        = !out_valid_reg || !result_stall;
        step           = in_valid_reg && advance;
        item_stall     = in_valid_reg && !advance;
        accept         = item_valid && !item_stall;
        in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? (step && res.valid) : out_valid_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg   <= rx_byte;
            in_start_reg  <= frame_start;
            in_rewind_reg <= rewind;
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (step && res.valid)
        begin
            out_outcome_reg <= res.outcome;
            out_seg_reg     <= res.segment_index;
            out_crc_reg     <= res.computed_crc;
        end
    end

    assign result_valid  = out_valid_reg;
    assign outcome       = out_outcome_reg;
    assign segment_index = out_seg_reg;
    assign computed_crc  = out_crc_reg;

    // Checks
    `ACKFC_ASSERT(a_stall_only_full, clk, rst_n,
        !item_stall || (in_valid_reg && out_valid_reg), "item_stall without full pipeline")
    `ACKFC_ASSERT(a_bad_len_crc_zero, clk, rst_n,
        !(out_valid_reg && out_outcome_reg == ackfc_pkg::OUT_BAD_LEN) || out_crc_reg == 16'h0000,
        "bad length result with nonzero CRC")
    `ACKFC_ASSERT(a_next_seg_nonzero, clk, rst_n,
        !(out_valid_reg && out_outcome_reg == ackfc_pkg::OUT_SEND_NEXT) || out_seg_reg != 16'h0000,
        "send next with segment index zero")
    `ACKFC_ASSERT_NEXT(a_no_result_drains, clk, rst_n,
        advance && !(step && res.valid), !result_valid, "result register not drained")

endmodule

FILE: rtl/core/ackfc_cfg.sv
// Configuration register file for the ack frame checker
module ackfc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ackfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ackfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ackfc_pkg::cfg_t                   cfg
);

    ackfc_pkg::cfg_t cfg_reg;
    ackfc_pkg::cfg_t cfg_next;

    // Address decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (ackfc_pkg::cfg_reg_t'(cfg_index))
                ackfc_pkg::REG_HEADER_CODE:   cfg_next.header_code        = cfg_data[7:0];
                ackfc_pkg::REG_RESP_TYPE:     cfg_next.response_type_code = cfg_data[7:0];
                ackfc_pkg::REG_RECEIVED_CODE: cfg_next.received_code      = cfg_data[7:0];
                ackfc_pkg::REG_NO_ERROR_CODE: cfg_next.no_error_code      = cfg_data[7:0];
                ackfc_pkg::REG_SEGMENT_COUNT: cfg_next.segment_count      = cfg_data[15:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/ackfc_frame.sv
// Frame parser, CRC accumulator, acknowledgement judge and segment index
module ackfc_frame (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    input  logic             frame_start,
    input  logic             rewind,
    input  ackfc_pkg::cfg_t  cfg,
    output ackfc_pkg::res_t  res
);

    logic        active_reg,  active_next;
    logic [15:0] pos_reg,     pos_next;
    logic [15:0] len_reg,     len_next;
    logic [15:0] crc_reg,     crc_next;
    logic [15:0] rcrc_reg,    rcrc_next;
    logic [1:0]  hto_reg,     hto_next;
    logic [7:0]  kind_reg,    kind_next;
    logic [7:0]  fs_reg,      fs_next;
    logic [7:0]  ds_reg,      ds_next;
    logic [15:0] seg_reg,     seg_next;

    // Frame state as seen by this byte (cleared on frame start)
    logic        act_b;
    logic [15:0] pos_b, len_b, crc_b, rcrc_b;
    logic [1:0]  hto_b;
    logic [7:0]  kind_b, fs_b, ds_b;
    logic        feed;
    logic [16:0] pos_p1, pos_p2;
    logic [15:0] seg_inc;
    ackfc_pkg::outcome_t verdict;

    always_comb
    begin
        act_b  = frame_start | active_reg;
        pos_b  = frame_start ? '0 : pos_reg;
        len_b  = frame_start ? '0 : len_reg;
        crc_b  = frame_start ? '0 : crc_reg;
        rcrc_b = frame_start ? '0 : rcrc_reg;
        hto_b  = frame_start ? '0 : hto_reg;
        kind_b = frame_start ? '0 : kind_reg;
        fs_b   = frame_start ? '0 : fs_reg;
        ds_b   = frame_start ? '0 : ds_reg;
        pos_p1 = {1'b0, pos_b} + 17'd1;
        pos_p2 = {1'b0, pos_b} + 17'd2;
        feed   = (pos_b <= 16'd3) || (pos_p2 < {1'b0, len_b});
    end

    // Acknowledgement verdict at the last byte (no CRC feed on the trailer bytes)
    always_comb
    begin
        seg_inc = (seg_reg != ackfc_pkg::SEG_MAX) ? seg_reg + 16'd1 : seg_reg;
        if (hto_b != 2'b11)
            verdict = ackfc_pkg::OUT_IGNORED;
        else if (crc_b != {rcrc_b[15:8], rx_byte})
            verdict = ackfc_pkg::OUT_CRC_ERROR;
        else if (kind_b != ackfc_pkg::ACK_KIND)
            verdict = ackfc_pkg::OUT_IGNORED;
        else if (fs_b != cfg.received_code)
            verdict = ackfc_pkg::OUT_IGNORED;
        else if (ds_b == cfg.no_error_code)
            verdict = (seg_inc < cfg.segment_count) ? ackfc_pkg::OUT_SEND_NEXT
                                                    : ackfc_pkg::OUT_COMPLETE;
        else
            verdict = (seg_reg < cfg.segment_count) ? ackfc_pkg::OUT_RESEND
                                                    : ackfc_pkg::OUT_COMPLETE;
    end

    // Per-byte state update
    always_comb
    begin
        active_next = active_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        crc_next    = crc_reg;
        rcrc_next   = rcrc_reg;
        hto_next    = hto_reg;
        kind_next   = kind_reg;
        fs_next     = fs_reg;
        ds_next     = ds_reg;
        seg_next    = seg_reg;
        res         = '0;

        if (rewind)
        begin
            seg_next = '0;
        end
        else if (act_b)
        begin
            active_next = 1'b1;
            len_next    = len_b;
            rcrc_next   = rcrc_b;
            hto_next    = hto_b;
            kind_next   = kind_b;
            fs_next     = fs_b;
            ds_next     = ds_b;
            crc_next    = feed ? ackfc_pkg::crc16_byte(crc_b, rx_byte) : crc_b;
            pos_next    = (pos_b != ackfc_pkg::POS_MAX) ? pos_p1[15:0] : pos_b;

            // Header fields by position
            case (pos_b)
                16'd0: if (rx_byte == cfg.header_code)        hto_next = hto_b | 2'b01;
                16'd1: if (rx_byte == cfg.response_type_code) hto_next = hto_b | 2'b10;
                16'd2: len_next  = {rx_byte, 8'h00};
                16'd3: len_next  = {len_b[15:8], rx_byte};
                16'd4: kind_next = rx_byte;
                16'd5: fs_next   = rx_byte;
                16'd6: ds_next   = rx_byte;
                default: ;
            endcase

            // Short frame ends right after the length field
            if (pos_b == 16'd3 && len_next < ackfc_pkg::MIN_FRAME_LEN)
            begin
                active_next       = 1'b0;
                pos_next          = pos_b;
                res.valid         = 1'b1;
                res.outcome       = ackfc_pkg::OUT_BAD_LEN;
                res.segment_index = seg_reg;
                res.computed_crc  = '0;
            end
            else if (pos_b >= 16'd4)
            begin
                if (pos_p2 == {1'b0, len_b})
                begin
                    rcrc_next = {rx_byte, 8'h00};
                end
                else if (pos_p1 == {1'b0, len_b})
                begin
                    rcrc_next   = {rcrc_b[15:8], rx_byte};
                    active_next = 1'b0;
                    pos_next    = pos_b;
                    if (verdict == ackfc_pkg::OUT_SEND_NEXT ||
                        (verdict == ackfc_pkg::OUT_COMPLETE && ds_b == cfg.no_error_code))
                        seg_next = seg_inc;
                    res.valid         = 1'b1;
                    res.outcome       = verdict;
                    res.segment_index = seg_next;
                    res.computed_crc  = crc_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
            len_reg    <= '0;
            crc_reg    <= '0;
            rcrc_reg   <= '0;
            hto_reg    <= '0;
            kind_reg   <= '0;
            fs_reg     <= '0;
            ds_reg     <= '0;
            seg_reg    <= '0;
        end
        else if (step)
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            crc_reg    <= crc_next;
            rcrc_reg   <= rcrc_next;
            hto_reg    <= hto_next;
            kind_reg   <= kind_next;
            fs_reg     <= fs_next;
            ds_reg     <= ds_next;
            seg_reg    <= seg_next;
        end
    end

endmodule
